// ===== rtl/bglpr_pkg.sv =====
// Shared types and constants of the background layer pixel renderer.
// Used by bglpr_csr, bglpr_shade and the top level; depends on nothing.
package bglpr_pkg;

   localparam int VRAM_BYTES      = 8192;
   localparam int VRAM_ADDR_W     = $clog2(VRAM_BYTES);
   localparam int BANK_DEPTH      = VRAM_BYTES / 2;
   localparam int BANK_ADDR_W     = $clog2(BANK_DEPTH);
   localparam int VISIBLE_LINES   = 144;
   localparam int VISIBLE_COLUMNS = 160;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // Video memory offsets relative to 0x8000.
   localparam logic [VRAM_ADDR_W-1:0] MAP_LOW_OFS      = 13'h1800;
   localparam logic [VRAM_ADDR_W-1:0] MAP_HIGH_OFS     = 13'h1C00;
   localparam logic [VRAM_ADDR_W-1:0] TILES_SIGNED_OFS = 13'h0800;

   localparam int LCDC_MAP_HIGH_BIT = 3;
   localparam int LCDC_UNSIGNED_BIT = 4;

   localparam logic       CMD_WRITE = 1'b0;
   localparam logic       CMD_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_LCD_CONTROL  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BG_PALETTE   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCROLL_Y     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SCROLL_X     = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SHADE_COLOR0 = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SHADE_COLOR1 = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SHADE_COLOR2 = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SHADE_COLOR3 = 4'd7;

   localparam logic [7:0]  LCDC_RESET    = 8'h91;
   localparam logic [7:0]  PALETTE_RESET = 8'hFC;
   localparam logic [31:0] SHADE0_RESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] SHADE1_RESET  = 32'hFFC0_C0C0;
   localparam logic [31:0] SHADE2_RESET  = 32'hFF60_6060;
   localparam logic [31:0] SHADE3_RESET  = 32'hFF00_0000;

   typedef struct packed {
      logic [7:0]       lcd_control;
      logic [7:0]       bg_palette;
      logic [7:0]       scroll_y;
      logic [7:0]       scroll_x;
      logic [3:0][31:0] shade_colour;
   } cfg_type;

endpackage

// ===== rtl/bglpr_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module bglpr_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bglpr_csr.sv =====
// Configuration registers of the background renderer.
// Depends on bglpr_pkg for the register indexes, reset values and cfg_type.
module bglpr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bglpr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bglpr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output bglpr_pkg::cfg_type                   cfg
);

   bglpr_pkg::cfg_type cfg_ff;
   bglpr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bglpr_pkg::REG_LCD_CONTROL:  cfg_in.lcd_control     = csr_wdata[7:0];
            bglpr_pkg::REG_BG_PALETTE:   cfg_in.bg_palette      = csr_wdata[7:0];
            bglpr_pkg::REG_SCROLL_Y:     cfg_in.scroll_y        = csr_wdata[7:0];
            bglpr_pkg::REG_SCROLL_X:     cfg_in.scroll_x        = csr_wdata[7:0];
            bglpr_pkg::REG_SHADE_COLOR0: cfg_in.shade_colour[0] = csr_wdata;
            bglpr_pkg::REG_SHADE_COLOR1: cfg_in.shade_colour[1] = csr_wdata;
            bglpr_pkg::REG_SHADE_COLOR2: cfg_in.shade_colour[2] = csr_wdata;
            bglpr_pkg::REG_SHADE_COLOR3: cfg_in.shade_colour[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lcd_control     <= bglpr_pkg::LCDC_RESET;
         cfg_ff.bg_palette      <= bglpr_pkg::PALETTE_RESET;
         cfg_ff.scroll_y        <= '0;
         cfg_ff.scroll_x        <= '0;
         cfg_ff.shade_colour[0] <= bglpr_pkg::SHADE0_RESET;
         cfg_ff.shade_colour[1] <= bglpr_pkg::SHADE1_RESET;
         cfg_ff.shade_colour[2] <= bglpr_pkg::SHADE2_RESET;
         cfg_ff.shade_colour[3] <= bglpr_pkg::SHADE3_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bglpr_shade.sv =====
// Pixel index, palette lookup, shade colour and the result output register.
// Depends on bglpr_pkg for cfg_type.
module bglpr_shade (
   input  logic               clock,
   input  logic               reset,
   input  bglpr_pkg::cfg_type cfg,
   input  logic               load,
   input  logic [7:0]         plane_lo,
   input  logic [7:0]         plane_hi,
   input  logic [2:0]         pixel_x,
   output logic               can_load,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_pixel_argb,
   output logic [1:0]         rsp_shade_number
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] argb_ff;
   logic [1:0]  shade_ff;
   logic [2:0]  bit_sel;
   logic [1:0]  color_idx;
   logic [1:0]  shade;

   // Pixel 0 of a tile row sits in bit 7 of each plane.
   assign bit_sel   = ~pixel_x;
   assign color_idx = {plane_hi[bit_sel], plane_lo[bit_sel]};
   assign shade     = cfg.bg_palette[{color_idx, 1'b0} +: 2];

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         argb_ff  <= cfg.shade_colour[shade];
         shade_ff <= shade;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pixel_argb   = argb_ff;
   assign rsp_shade_number = shade_ff;

endmodule

// ===== rtl/background_layer_pixel_render_top.sv =====
// Top level of the background layer pixel renderer: sequencer and video memory banks.
// Depends on bglpr_pkg, bglpr_csr, bglpr_ram and bglpr_shade.
//
//   Channel   Direction  Ports                                    Handshake
//   req       in         cmd, mem_offset, mem_byte, col, line      req_valid / req_ready
//   rsp       out        pixel_argb, shade_number                  rsp_valid / rsp_ready
//   csr       in         csr_index, csr_wdata                      csr_we, no wait
//
// A write beat is stored at the edge it is accepted. A query runs as follows:
// the map byte is read at the accept edge, the two tile planes at the edge that leaves
// the fetch state, and the result register loads on the edge that leaves the shade state,
// where the next beat may enter. The tile row read uses the read ports of both banks.
// Reset is synchronous and clears the sequencer, output valid and configuration registers;
// video memory contents are not cleared. A stalled result holds the last stage.
module background_layer_pixel_render_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [12:0]                       req_mem_offset,
   input  logic [7:0]                        req_mem_byte,
   input  logic [7:0]                        req_screen_col,
   input  logic [7:0]                        req_screen_line,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_pixel_argb,
   output logic [1:0]                        rsp_shade_number,
   input  logic                              csr_we,
   input  logic [bglpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bglpr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SHADE = 2'd2;

   bglpr_pkg::cfg_type cfg;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic [2:0] pix_x_ff;
   logic [2:0] pix_y_ff;
   logic       map_odd_ff;

   logic       accept;
   logic       on_screen;
   logic       start_query;
   logic       can_load;
   logic       load;

   logic [7:0] bx;
   logic [7:0] by;
   logic [bglpr_pkg::VRAM_ADDR_W-1:0] map_addr;
   logic [bglpr_pkg::VRAM_ADDR_W-1:0] row_addr;
   logic [bglpr_pkg::VRAM_ADDR_W-1:0] tile_base;
   logic [7:0] tile;

   logic                              even_we;
   logic                              odd_we;
   logic                              even_re;
   logic                              odd_re;
   logic [bglpr_pkg::BANK_ADDR_W-1:0] even_raddr;
   logic [bglpr_pkg::BANK_ADDR_W-1:0] odd_raddr;
   logic [7:0]                        even_rdata;
   logic [7:0]                        odd_rdata;

   bglpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_SHADE) && can_load);
   assign accept    = req_valid && req_ready;
   assign on_screen = ({1'b0, req_screen_col} < 9'(bglpr_pkg::VISIBLE_COLUMNS))
                   && ({1'b0, req_screen_line} < 9'(bglpr_pkg::VISIBLE_LINES));
   assign start_query = accept && (req_cmd == bglpr_pkg::CMD_QUERY) && on_screen;
   assign load        = (state_ff == ST_SHADE) && can_load;

   // Scrolled position wraps at 256 by plain 8-bit addition.
   assign bx = req_screen_col + cfg.scroll_x;
   assign by = req_screen_line + cfg.scroll_y;

   assign map_addr = (cfg.lcd_control[bglpr_pkg::LCDC_MAP_HIGH_BIT]
                        ? bglpr_pkg::MAP_HIGH_OFS : bglpr_pkg::MAP_LOW_OFS)
                   + {3'b000, by[7:3], bx[7:3]};

   // Signed tile mode: flipping bit 7 against base 0x8800 gives the signed offset.
   assign tile = map_odd_ff ? odd_rdata : even_rdata;
   assign tile_base = cfg.lcd_control[bglpr_pkg::LCDC_UNSIGNED_BIT]
                    ? '0 : bglpr_pkg::TILES_SIGNED_OFS;
   assign row_addr = tile_base
                   + {1'b0, (cfg.lcd_control[bglpr_pkg::LCDC_UNSIGNED_BIT]
                             ? tile : {~tile[7], tile[6:0]}), pix_y_ff, 1'b0};

   // Even bytes and odd bytes live in separate banks so a tile row is one read.
   assign even_we = accept && (req_cmd == bglpr_pkg::CMD_WRITE) && !req_mem_offset[0];
   assign odd_we  = accept && (req_cmd == bglpr_pkg::CMD_WRITE) && req_mem_offset[0];

   always_comb begin
      even_re    = 1'b0;
      odd_re     = 1'b0;
      even_raddr = map_addr[bglpr_pkg::VRAM_ADDR_W-1:1];
      odd_raddr  = map_addr[bglpr_pkg::VRAM_ADDR_W-1:1];
      if (state_ff == ST_FETCH) begin
         even_re    = 1'b1;
         odd_re     = 1'b1;
         even_raddr = row_addr[bglpr_pkg::VRAM_ADDR_W-1:1];
         odd_raddr  = row_addr[bglpr_pkg::VRAM_ADDR_W-1:1];
      end else if (start_query) begin
         even_re = !map_addr[0];
         odd_re  = map_addr[0];
      end
   end

   bglpr_ram #(
      .DEPTH (bglpr_pkg::BANK_DEPTH),
      .WIDTH (8)
   ) u_bank_even (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (req_mem_offset[bglpr_pkg::VRAM_ADDR_W-1:1]),
      .wr_data (req_mem_byte),
      .rd_en   (even_re),
      .rd_addr (even_raddr),
      .rd_data (even_rdata)
   );

   bglpr_ram #(
      .DEPTH (bglpr_pkg::BANK_DEPTH),
      .WIDTH (8)
   ) u_bank_odd (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (req_mem_offset[bglpr_pkg::VRAM_ADDR_W-1:1]),
      .wr_data (req_mem_byte),
      .rd_en   (odd_re),
      .rd_addr (odd_raddr),
      .rd_data (odd_rdata)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start_query) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_SHADE;
         ST_SHADE: begin
            if (can_load) begin
               state_in = start_query ? ST_FETCH : ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start_query) begin
         pix_x_ff   <= bx[2:0];
         pix_y_ff   <= by[2:0];
         map_odd_ff <= map_addr[0];
      end
   end

   bglpr_shade u_shade (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .load             (load),
      .plane_lo         (even_rdata),
      .plane_hi         (odd_rdata),
      .pixel_x          (pix_x_ff),
      .can_load         (can_load),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_argb   (rsp_pixel_argb),
      .rsp_shade_number (rsp_shade_number)
   );

   // The tile row fetch state is always followed directly by the shade state.
   a_fetch_then_shade: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |=> state_ff == ST_SHADE)
      else $error("tile row fetch not followed by shade stage");

   // No beat may enter while the read ports are busy with a tile row.
   a_no_accept_in_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> !req_ready)
      else $error("beat accepted during tile row fetch");

   // A new result only appears after the shade stage.
   a_result_from_shade: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_SHADE)
      else $error("result appeared without a shade stage");

endmodule
